// ===== src/mas_pkg.sv =====
// Shared types, constants and codes of the maximum-average segment search block.
`default_nettype none
package mas_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int INT_BITS   = 8;
  localparam int MAX_ITEMS  = 1024;
  localparam int SAMPLE_W   = 8;
  localparam int MEAN_W     = INT_BITS + FRAC_BITS;
  localparam int HALVINGS   = INT_BITS + FRAC_BITS;
  localparam int HALF_W     = $clog2(HALVINGS + 1);
  localparam int MINLEN_W   = 11;
  localparam int HIGH_W     = 8;
  localparam int CFG_DATA_W = 11;
  localparam int SEG_W      = 10;
  localparam int BEST_W     = 24;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MIN_LENGTH  = 1'b0,
    CFG_SEARCH_HIGH = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [SEG_W-1:0]  segment_start;
    logic [SEG_W-1:0]  segment_end;
    logic [BEST_W-1:0] best_mean;
  } out_item_t;

  typedef enum logic [2:0] {
    S_LOAD,
    S_SETUP,
    S_CHECK,
    S_PSTART,
    S_PRUN,
    S_PEND,
    S_FINISH
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store;
    logic init;
    logic pstart;
    logic final_sel;
    logic run;
    logic update;
    logic publish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic enough;
    logic done;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

// ===== src/mas_ctrl.sv =====
// Sequencer for loading, the binary-search probes and result hand-off.
`default_nettype none
module mas_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  input  wire mas_pkg::stat_t stat,
  output mas_pkg::cmd_t      cmd
);

  mas_pkg::state_t state_r, state_nxt;
  logic [mas_pkg::HALF_W-1:0] halve_r, halve_nxt;
  logic last_probe;

  assign last_probe = (halve_r == mas_pkg::HALF_W'(mas_pkg::HALVINGS));

  // Hold state and halving count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mas_pkg::S_LOAD;
      halve_r <= '0;
    end else begin
      state_r <= state_nxt;
      halve_r <= halve_nxt;
    end
  end

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    halve_nxt = halve_r;
    unique case (state_r)
      mas_pkg::S_LOAD: begin
        if (in_valid && in_last) state_nxt = mas_pkg::S_SETUP;
      end
      mas_pkg::S_SETUP: begin
        halve_nxt = '0;
        state_nxt = mas_pkg::S_CHECK;
      end
      mas_pkg::S_CHECK: begin
        state_nxt = stat.enough ? mas_pkg::S_PSTART : mas_pkg::S_FINISH;
      end
      mas_pkg::S_PSTART: begin
        state_nxt = mas_pkg::S_PRUN;
      end
      mas_pkg::S_PRUN: begin
        if (stat.done) state_nxt = mas_pkg::S_PEND;
      end
      mas_pkg::S_PEND: begin
        if (last_probe) begin
          state_nxt = mas_pkg::S_FINISH;
        end else begin
          halve_nxt = halve_r + 1'b1;
          state_nxt = mas_pkg::S_PSTART;
        end
      end
      mas_pkg::S_FINISH: begin
        if (!stat.out_busy) state_nxt = mas_pkg::S_LOAD;
      end
      default: state_nxt = mas_pkg::S_LOAD;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd          = '0;
    in_ready     = (state_r == mas_pkg::S_LOAD);
    cmd.store    = (state_r == mas_pkg::S_LOAD) && in_valid;
    cmd.init     = (state_r == mas_pkg::S_SETUP);
    cmd.pstart   = (state_r == mas_pkg::S_PSTART);
    cmd.final_sel = last_probe;
    cmd.run      = (state_r == mas_pkg::S_PRUN);
    cmd.update   = (state_r == mas_pkg::S_PEND) && !last_probe;
    cmd.publish  = (state_r == mas_pkg::S_FINISH) && !stat.out_busy;
  end

  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store && in_last |=> state_r == mas_pkg::S_SETUP)
    else $error("last request did not start the search");

  a_publish_returns: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> state_r == mas_pkg::S_LOAD)
    else $error("publish did not return to load");

  a_halve_bound: assert property (@(posedge clk) disable iff (!rst_n)
    halve_r <= mas_pkg::HALF_W'(mas_pkg::HALVINGS))
    else $error("halving count overran");

endmodule
`default_nettype wire

// ===== src/mas_dp.sv =====
// Sample store, search interval, probe pipeline and result register.
`default_nettype none
module mas_dp #(
  parameter int MAX_ITEMS = mas_pkg::MAX_ITEMS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [0:0]                    cfg_index,
  input  wire logic [mas_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire mas_pkg::in_item_t             in_data,
  input  wire mas_pkg::cmd_t                 cmd,
  output mas_pkg::stat_t                     stat,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mas_pkg::out_item_t                 out_data
);

  localparam int AW  = $clog2(MAX_ITEMS);
  localparam int CW  = $clog2(MAX_ITEMS + 1);
  localparam int LW  = (CW > mas_pkg::MINLEN_W) ? CW : mas_pkg::MINLEN_W;
  localparam int VW  = (mas_pkg::INT_BITS > mas_pkg::SAMPLE_W) ?
                       mas_pkg::INT_BITS : mas_pkg::SAMPLE_W;
  localparam int PW  = CW + VW + mas_pkg::FRAC_BITS + 1;
  localparam int MW  = mas_pkg::MEAN_W;

  logic [mas_pkg::SAMPLE_W-1:0] mem [MAX_ITEMS];

  logic [mas_pkg::MINLEN_W-1:0] min_len_r;
  logic [mas_pkg::HIGH_W-1:0]   high_r;
  logic [mas_pkg::MINLEN_W-1:0] len_r;
  logic [CW-1:0]                count_r;
  logic [MW-1:0]                low_r, top_r, mean_r, mid;
  logic [CW-1:0]                iss_r;
  logic [LW-1:0]                k_full;
  logic                         k_ok, issue;

  logic                         v1_r, v2_r;
  logic [mas_pkg::SAMPLE_W-1:0] rd_a_r, rd_b_r;
  logic                         p1_kok_r, p2_kok_r;
  logic [CW-1:0]                p1_i_r, p2_i_r, p1_k_r, p2_k_r;
  logic signed [PW-1:0]         da_r, db_r;
  logic signed [PW-1:0]         running_r, lagged_r, least_r;
  logic signed [PW-1:0]         run_n, lag_n;
  logic [CW-1:0]                start_r, end_r;
  logic                         hit_r;
  logic                         out_valid_r;
  mas_pkg::out_item_t           out_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r <= mas_pkg::MINLEN_W'(1);
      high_r    <= mas_pkg::HIGH_W'(100);
    end else if (cfg_we) begin
      unique case (mas_pkg::cfg_idx_t'(cfg_index))
        mas_pkg::CFG_MIN_LENGTH:  min_len_r <= cfg_data[mas_pkg::MINLEN_W-1:0];
        mas_pkg::CFG_SEARCH_HIGH: high_r    <= cfg_data[mas_pkg::HIGH_W-1:0];
        default: ;
      endcase
    end
  end

  // Store samples, drop them once the store is full
  always_ff @(posedge clk) begin
    if (cmd.store && (count_r < CW'(MAX_ITEMS))) mem[count_r[AW-1:0]] <= in_data.sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.publish) begin
      count_r <= '0;
    end else if (cmd.store && (count_r < CW'(MAX_ITEMS))) begin
      count_r <= count_r + 1'b1;
    end
  end

  // Search interval
  assign mid = low_r + ((top_r - low_r) >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
      top_r <= MW'(mas_pkg::HIGH_W'(100)) << mas_pkg::FRAC_BITS;
    end else if (cmd.init) begin
      low_r <= '0;
      top_r <= MW'(high_r) << mas_pkg::FRAC_BITS;
    end else if (cmd.update) begin
      if (hit_r) low_r <= mean_r;
      else       top_r <= mean_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) len_r <= (min_len_r == '0) ? mas_pkg::MINLEN_W'(1) : min_len_r;
    if (cmd.pstart) mean_r <= cmd.final_sel ? low_r : mid;
  end

  // Issue two reads a cycle: the new sample and the one min_length-1 back
  assign k_full = LW'(iss_r) + LW'(1) - LW'(len_r);
  assign k_ok   = (LW'(iss_r) + LW'(1)) >= LW'(len_r);
  assign issue  = cmd.run && !hit_r && (iss_r < count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else if (cmd.pstart) begin
      iss_r <= '0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
    end else begin
      if (issue) iss_r <= iss_r + 1'b1;
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_a_r   <= mem[iss_r[AW-1:0]];
    rd_b_r   <= mem[k_full[AW-1:0]];
    p1_i_r   <= iss_r;
    p1_kok_r <= k_ok;
    p1_k_r   <= CW'(k_full);
  end

  // Scale samples and subtract the probe mean
  always_ff @(posedge clk) begin
    da_r     <= $signed(PW'(rd_a_r) << mas_pkg::FRAC_BITS) - $signed(PW'(mean_r));
    db_r     <= $signed(PW'(rd_b_r) << mas_pkg::FRAC_BITS) - $signed(PW'(mean_r));
    p2_i_r   <= p1_i_r;
    p2_kok_r <= p1_kok_r;
    p2_k_r   <= p1_k_r;
  end

  // Accumulate prefixes and test for a qualifying segment
  assign run_n = running_r + da_r;
  assign lag_n = lagged_r + db_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (cmd.pstart) begin
      hit_r <= 1'b0;
    end else if (v2_r && !hit_r && p2_kok_r && (run_n >= least_r)) begin
      hit_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pstart) begin
      running_r <= '0;
      lagged_r  <= '0;
      least_r   <= '0;
      start_r   <= '0;
      end_r     <= '0;
    end else if (v2_r && !hit_r) begin
      running_r <= run_n;
      if (p2_kok_r) begin
        lagged_r <= lag_n;
        if (run_n >= least_r) begin
          end_r <= p2_i_r;
        end else if (least_r > lag_n) begin
          least_r <= lag_n;
          start_r <= p2_k_r + 1'b1;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      if (stat.enough && hit_r) begin
        out_r.found         <= 1'b1;
        out_r.segment_start <= mas_pkg::SEG_W'(start_r);
        out_r.segment_end   <= mas_pkg::SEG_W'(end_r);
        out_r.best_mean     <= mas_pkg::BEST_W'(low_r);
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    stat.enough   = LW'(count_r) >= LW'(len_r);
    stat.done     = hit_r || ((iss_r == count_r) && !v1_r && !v2_r);
    stat.out_busy = out_valid_r && !out_ready;
  end

  a_interval: assert property (@(posedge clk) disable iff (!rst_n)
    low_r <= top_r)
    else $error("search interval inverted");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_ITEMS))
    else $error("sample count overran the store");

  a_hit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r && !cmd.pstart |=> hit_r && $stable(end_r) && $stable(start_r))
    else $error("segment changed after a hit");

endmodule
`default_nettype wire

// ===== src/max_average_segment_min_length_unit.sv =====
// Top level of the maximum-average segment search with a minimum length.
// Samples are taken one per cycle into an internal store of MAX_ITEMS
// entries; the request flagged last starts a fixed-point binary search of
// INT_BITS+FRAC_BITS halvings plus one final pass, each pass streaming the
// stored samples through a three-stage pipeline at one sample per cycle over
// the store's two read ports. A pass ends early at the first qualifying
// segment, and with too few samples no pass is made; no request is taken
// while the search runs. The result waits in an output register, and
// loading of the next sequence may begin while it waits; the following
// search holds at its end until that register is free.
`default_nettype none
module max_average_segment_min_length_unit #(
  parameter int MAX_ITEMS = mas_pkg::MAX_ITEMS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire mas_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output mas_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_we,
  input  wire logic [0:0]                     cfg_index,
  input  wire logic [mas_pkg::CFG_DATA_W-1:0] cfg_data
);

  mas_pkg::cmd_t  cmd;
  mas_pkg::stat_t stat;

  mas_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mas_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
